[rtl/bvwh_pkg.sv]
// ----------------------------------------------------------------------------
// bvwh_pkg
// Shared types and codes of the binned velocity / work histogram block.
// ----------------------------------------------------------------------------
package bvwh_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_PHASE     = 3'd0;
	localparam logic [2:0] REG_FWD_START = 3'd1;
	localparam logic [2:0] REG_FWD_WIDTH = 3'd2;
	localparam logic [2:0] REG_REV_START = 3'd3;
	localparam logic [2:0] REG_REV_WIDTH = 3'd4;
	localparam logic [2:0] REG_STEP_TIME = 3'd5;

	// Request types and read selectors.
	localparam logic       REQ_SAMPLE = 1'b0;
	localparam logic       REQ_READ   = 1'b1;
	localparam logic [1:0] WH_VEL     = 2'd0;
	localparam logic [1:0] WH_WORK    = 2'd1;
	localparam logic [1:0] WH_RNG     = 2'd2;

	// Divider widths: magnitude of the largest dividend, divisor, signed quotient.
	localparam int NUM_W = 65;
	localparam int DEN_W = 34;
	localparam int QUO_W = 66;

	typedef struct packed {
		logic               phase;
		logic signed [31:0] fwd_start;
		logic signed [31:0] fwd_width;
		logic signed [31:0] rev_start;
		logic signed [31:0] rev_width;
		logic        [31:0] step_time;
	} cfg_t;

	typedef struct packed {
		logic               is_read;
		logic               read_ok;
		logic               dir;
		logic        [5:0]  sb;
		logic        [1:0]  which;
		logic        [5:0]  hb;
		logic signed [31:0] x1;
		logic signed [31:0] x2;
		logic signed [31:0] wk;
		logic signed [32:0] dx;
	} qitem_t;

	typedef struct packed {
		logic               accepted;
		logic               direction;
		logic        [5:0]  space_bin;
		logic        [31:0] hit_count;
		logic        [47:0] weight_sum;
		logic signed [47:0] work_sum;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
	} res_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

[rtl/bvwh_front.sv]
// ----------------------------------------------------------------------------
// bvwh_front
// Accepts request beats, classifies them (step, table choice, read checks)
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bvwh_front import bvwh_pkg::*; #(
	parameter int SPACE_BINS    = 64,
	parameter int VELOCITY_BINS = 64,
	parameter int WORK_BINS     = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               hold,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [31:0] pos_start,
	input  logic signed [31:0] pos_end,
	input  logic signed [31:0] work,
	input  logic               read_direction,
	input  logic        [5:0]  read_space_bin,
	input  logic        [1:0]  read_which,
	input  logic        [5:0]  read_hist_bin,
	output logic               q_valid,
	output qitem_t             q_item,
	input  logic               q_pop
);

	qitem_t      ent_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        push;
	qitem_t      cls;
	logic signed [32:0] dx;
	logic        dpos, dneg, fpos, fneg, prod_pos, prod_neg, fwd;
	logic        hb_ok;

	assign in_stall = hold || (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	assign dx = $signed({pos_end[31], pos_end}) - $signed({pos_start[31], pos_start});

	// Table choice follows the sign of step times forward width; phase 1
	// also sends a zero product to the forward table.
	always_comb begin
		dpos     = !dx[32] && (dx != 33'sd0);
		dneg     = dx[32];
		fpos     = !cfg.fwd_width[31] && (cfg.fwd_width != 32'sd0);
		fneg     = cfg.fwd_width[31];
		prod_pos = (dpos && fpos) || (dneg && fneg);
		prod_neg = (dpos && fneg) || (dneg && fpos);
		fwd      = cfg.phase ? !prod_neg : prod_pos;
	end

	always_comb begin
		case (read_which)
			WH_VEL:  hb_ok = 32'(read_hist_bin) < 32'(VELOCITY_BINS);
			WH_WORK: hb_ok = 32'(read_hist_bin) < 32'(WORK_BINS);
			WH_RNG:  hb_ok = read_hist_bin <= 6'd1;
			default: hb_ok = 1'b0;
		endcase
	end

	always_comb begin
		cls.is_read = (req_type == REQ_READ);
		cls.read_ok = hb_ok && (32'(read_space_bin) < 32'(SPACE_BINS));
		cls.dir     = (req_type == REQ_READ) ? read_direction : !fwd;
		cls.sb      = read_space_bin;
		cls.which   = read_which;
		cls.hb      = read_hist_bin;
		cls.x1      = pos_start;
		cls.x2      = pos_end;
		cls.wk      = work;
		cls.dx      = dx;
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/bvwh_div.sv]
// ----------------------------------------------------------------------------
// bvwh_div
// Signed floor divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvwh_div import bvwh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dmag_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [6:0]       cnt_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   nrem;
	logic [QUO_W-1:0] qpos;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, dmag_q};
	assign nrem  = ge ? (trial - {1'b0, dmag_q}) : trial;
	assign qpos  = {1'b0, nq_q};

	// Truncated magnitude quotient, turned into a floor quotient for mixed signs.
	always_comb begin
		rsp.done = done_q;
		if (neg_q) rsp.quo = -$signed(qpos) - ((rem_q != '0) ? 66'sd1 : 66'sd0);
		else rsp.quo = $signed(qpos);
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q   <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
			dmag_q <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
			neg_q  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= nrem[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/bvwh_back.sv]
// ----------------------------------------------------------------------------
// bvwh_back
// Sequencer that carries out one request at a time: bin search, divisions,
// range tracking, histogram updates and table reads, plus the result register.
// ----------------------------------------------------------------------------
module bvwh_back import bvwh_pkg::*; #(
	parameter int SPACE_BINS    = 64,
	parameter int VELOCITY_BINS = 64,
	parameter int WORK_BINS     = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   q_valid,
	input  qitem_t q_item,
	output logic   q_pop,
	output logic   clearing,
	output logic   out_valid,
	input  logic   out_stall,
	output res_t   out_res
);

	localparam int NT     = 2 * SPACE_BINS;
	localparam int VDEPTH = NT * VELOCITY_BINS;
	localparam int WDEPTH = NT * WORK_BINS;
	localparam int CDEPTH = (VDEPTH > WDEPTH) ? VDEPTH : WDEPTH;
	localparam int TW     = $clog2(NT);
	localparam int VA     = $clog2(VDEPTH);
	localparam int WA     = $clog2(WDEPTH);
	localparam int CW     = $clog2(CDEPTH);
	localparam int IW     = (SPACE_BINS > 1) ? $clog2(SPACE_BINS) : 1;
	localparam int VJW    = (VELOCITY_BINS > 1) ? $clog2(VELOCITY_BINS) : 1;
	localparam int WJW    = (WORK_BINS > 1) ? $clog2(WORK_BINS) : 1;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;
	localparam logic signed [QUO_W-1:0] QS32_MAX = {{(QUO_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [QUO_W-1:0] QS32_MIN = {{(QUO_W-31){1'b1}}, {31{1'b0}}};

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_RDD   = 5'd3;
	localparam logic [4:0] S_CHK   = 5'd4;
	localparam logic [4:0] S_DIVI  = 5'd5;
	localparam logic [4:0] S_LO    = 5'd6;
	localparam logic [4:0] S_IN    = 5'd7;
	localparam logic [4:0] S_DIVV  = 5'd8;
	localparam logic [4:0] S_SW    = 5'd9;
	localparam logic [4:0] S_SWS   = 5'd10;
	localparam logic [4:0] S_SWD   = 5'd11;
	localparam logic [4:0] S_WT    = 5'd12;
	localparam logic [4:0] S_WTD   = 5'd13;
	localparam logic [4:0] S_P0    = 5'd14;
	localparam logic [4:0] S_VM    = 5'd15;
	localparam logic [4:0] S_VS    = 5'd16;
	localparam logic [4:0] S_VD    = 5'd17;
	localparam logic [4:0] S_VR    = 5'd18;
	localparam logic [4:0] S_VW    = 5'd19;
	localparam logic [4:0] S_WM    = 5'd20;
	localparam logic [4:0] S_WS    = 5'd21;
	localparam logic [4:0] S_WD    = 5'd22;
	localparam logic [4:0] S_WR    = 5'd23;
	localparam logic [4:0] S_WW    = 5'd24;
	localparam logic [4:0] S_OUT   = 5'd25;

	typedef struct packed {
		logic signed [31:0] vlo;
		logic signed [31:0] vhi;
		logic signed [31:0] wlo;
		logic signed [31:0] whi;
		logic signed [47:0] total;
		logic        [31:0] used;
	} bin_t;

	typedef struct packed {
		logic        [31:0] count;
		logic        [47:0] weight;
		logic signed [47:0] work;
	} vcell_t;

	typedef struct packed {
		logic [31:0] count;
		logic [47:0] weight;
	} wcell_t;

	localparam bin_t BIN_RESET = '{vlo: S32_MAX, vhi: S32_MIN, wlo: S32_MAX, whi: S32_MIN,
		total: 48'sd0, used: 32'd0};

	function automatic logic signed [31:0] sat32(input logic signed [QUO_W-1:0] v);
		if (v > QS32_MAX) return S32_MAX;
		else if (v < QS32_MIN) return S32_MIN;
		else return v[31:0];
	endfunction

	function automatic logic signed [47:0] sadd48(input logic signed [47:0] a,
		input logic signed [47:0] b);
		logic signed [48:0] s;
		s = $signed({a[47], a}) + $signed({b[47], b});
		if (s[48] != s[47]) return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else return s[47:0];
	endfunction

	function automatic logic [47:0] uadd48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? {48{1'b1}} : s[47:0];
	endfunction

	function automatic logic [31:0] inc32(input logic [31:0] c);
		return (&c) ? c : c + 32'd1;
	endfunction

	logic [4:0]    state_q;
	logic [CW-1:0] clr_q;
	logic          out_valid_q;
	res_t          out_q;

	qitem_t               it_q;
	res_t                 res_q;
	logic [IW-1:0]        i_q;
	logic [TW-1:0]        t_q;
	logic signed [47:0]   lo_q;
	logic signed [31:0]   v_q;
	logic signed [31:0]   sw_q;
	logic        [47:0]   wt_q;
	logic signed [NUM_W-1:0] prod_q;
	logic signed [DEN_W-1:0] den_q;
	logic [TW-1:0]        baddr_q;
	logic [VA-1:0]        vaddr_q;
	logic [WA-1:0]        waddr_q;

	bin_t   bmem [NT];
	vcell_t vmem [VDEPTH];
	wcell_t wmem [WDEPTH];
	bin_t   b_rd, b_wd;
	vcell_t v_rd, v_wd;
	wcell_t w_rd, w_wd;
	logic   b_we, b_re, v_we, v_re, w_we, w_re;
	logic [TW-1:0] b_wa;
	logic [VA-1:0] v_wa;
	logic [WA-1:0] w_wa;
	logic   clr_b, clr_v, clr_w;

	div_req_t dreq;
	div_rsp_t drsp;

	logic signed [31:0]   s_c, w_c;
	logic        [31:0]   absw;
	logic        [32:0]   absdx;
	logic signed [32:0]   xs_c;
	logic signed [IW+32:0] iw_prod;
	logic signed [47:0]   hi_c, x1e, x2e;
	logic                 inside_c;
	logic signed [32:0]   vdiff, wdiff, vspan, wspan;
	logic signed [44:0]   vm_prod, wm_prod;
	logic signed [65:0]   sw_prod;
	logic [31:0]          tread, vread, wread, tsamp, vsamp, wsamp;
	logic                 out_load;

	assign clearing  = (state_q == S_CLEAR);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		s_c      = it_q.dir ? cfg.rev_start : cfg.fwd_start;
		w_c      = it_q.dir ? cfg.rev_width : cfg.fwd_width;
		absw     = w_c[31] ? (~w_c + 32'd1) : w_c;
		absdx    = it_q.dx[32] ? (~it_q.dx + 33'd1) : it_q.dx;
		xs_c     = $signed({it_q.x1[31], it_q.x1}) - $signed({s_c[31], s_c});
		iw_prod  = $signed({1'b0, i_q}) * w_c;
		hi_c     = lo_q + 48'(w_c);
		x1e      = 48'(it_q.x1);
		x2e      = 48'(it_q.x2);
		// Both ends must lie strictly inside the bin, in the width's direction.
		if (!w_c[31])
			inside_c = (lo_q < x1e) && (x1e < hi_c) && (lo_q < x2e) && (x2e < hi_c);
		else
			inside_c = (lo_q > x1e) && (x1e > hi_c) && (lo_q > x2e) && (x2e > hi_c);
		vdiff    = $signed({v_q[31], v_q}) - $signed({b_rd.vlo[31], b_rd.vlo});
		wdiff    = $signed({sw_q[31], sw_q}) - $signed({b_rd.wlo[31], b_rd.wlo});
		vspan    = $signed({b_rd.vhi[31], b_rd.vhi}) - $signed({b_rd.vlo[31], b_rd.vlo});
		wspan    = $signed({b_rd.whi[31], b_rd.whi}) - $signed({b_rd.wlo[31], b_rd.wlo});
		vm_prod  = vdiff * $signed(12'(VELOCITY_BINS));
		wm_prod  = wdiff * $signed(12'(WORK_BINS));
		sw_prod  = it_q.wk * $signed({1'b0, absw});
		tread    = 32'(q_item.dir) * 32'(SPACE_BINS) + 32'(q_item.sb);
		vread    = tread * 32'(VELOCITY_BINS) + 32'(q_item.hb);
		wread    = tread * 32'(WORK_BINS) + 32'(q_item.hb);
		tsamp    = 32'(it_q.dir) * 32'(SPACE_BINS) + 32'(i_q);
		vsamp    = 32'(t_q) * 32'(VELOCITY_BINS) + 32'(drsp.quo[VJW-1:0]);
		wsamp    = 32'(t_q) * 32'(WORK_BINS) + 32'(drsp.quo[WJW-1:0]);
	end

	// Divider requests.
	always_comb begin
		dreq = '0;
		unique case (state_q)
			S_CHK: begin
				dreq.start = (w_c != 32'sd0);
				dreq.num   = NUM_W'(xs_c);
				dreq.den   = DEN_W'(w_c);
			end
			S_IN: begin
				dreq.start = inside_c && (cfg.step_time != 32'd0);
				dreq.num   = $signed(NUM_W'(it_q.dx)) <<< 16;
				dreq.den   = {2'b00, cfg.step_time};
			end
			S_SWS: begin
				dreq.start = 1'b1;
				dreq.num   = prod_q;
				dreq.den   = {1'b0, absdx};
			end
			S_WT: begin
				dreq.start = 1'b1;
				dreq.num   = {16'd0, absdx, 16'd0};
				dreq.den   = {2'b00, absw};
			end
			S_VS, S_WS: begin
				dreq.start = 1'b1;
				dreq.num   = prod_q;
				dreq.den   = den_q;
			end
			default: dreq = '0;
		endcase
	end

	bvwh_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	// Memory port control.
	always_comb begin
		clr_b = (state_q == S_CLEAR) && (32'(clr_q) < 32'(NT));
		clr_v = (state_q == S_CLEAR) && (32'(clr_q) < 32'(VDEPTH));
		clr_w = (state_q == S_CLEAR) && (32'(clr_q) < 32'(WDEPTH));
		b_we  = clr_b || (state_q == S_P0) || (state_q == S_WW);
		v_we  = clr_v || (state_q == S_VW);
		w_we  = clr_w || (state_q == S_WW);
		b_re  = (state_q == S_RD) || (state_q == S_IN);
		v_re  = (state_q == S_RD) || (state_q == S_VR);
		w_re  = (state_q == S_RD) || (state_q == S_WR);
		b_wa  = clearing ? clr_q[TW-1:0] : baddr_q;
		v_wa  = clearing ? clr_q[VA-1:0] : vaddr_q;
		w_wa  = clearing ? clr_q[WA-1:0] : waddr_q;

		b_wd = b_rd;
		if (clearing) begin
			b_wd = BIN_RESET;
		end else if (state_q == S_P0) begin
			if (v_q > b_rd.vhi) b_wd.vhi = v_q;
			if (v_q < b_rd.vlo) b_wd.vlo = v_q;
			if (it_q.dx != 33'sd0) begin
				if (sw_q > b_rd.whi) b_wd.whi = sw_q;
				if (sw_q < b_rd.wlo) b_wd.wlo = sw_q;
			end
		end else begin
			b_wd.total = sadd48(b_rd.total, 48'(sw_q));
			b_wd.used  = inc32(b_rd.used);
		end

		if (clearing) begin
			v_wd = '0;
		end else begin
			v_wd.count  = inc32(v_rd.count);
			v_wd.weight = uadd48(v_rd.weight, wt_q);
			v_wd.work   = sadd48(v_rd.work, 48'(it_q.wk));
		end

		if (clearing) begin
			w_wd = '0;
		end else begin
			w_wd.count  = inc32(w_rd.count);
			w_wd.weight = uadd48(w_rd.weight, wt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) bmem[b_wa] <= b_wd;
		if (b_re) b_rd <= bmem[baddr_q];
	end

	always_ff @(posedge clk) begin
		if (v_we) vmem[v_wa] <= v_wd;
		if (v_re) v_rd <= vmem[vaddr_q];
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_wa] <= w_wd;
		if (w_re) w_rd <= wmem[waddr_q];
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CDEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) state_q <= q_item.is_read ? S_RD : S_CHK;
				end
				S_RD:  state_q <= S_RDD;
				S_RDD: state_q <= S_OUT;
				S_CHK: state_q <= (w_c == 32'sd0) ? S_OUT : S_DIVI;
				S_DIVI: begin
					if (drsp.done) begin
						if (drsp.quo < 66'sd0 || drsp.quo >= $signed(66'(SPACE_BINS)))
							state_q <= S_OUT;
						else state_q <= S_LO;
					end
				end
				S_LO: state_q <= S_IN;
				S_IN: begin
					if (!inside_c) state_q <= S_OUT;
					else if (cfg.step_time == 32'd0) state_q <= S_SW;
					else state_q <= S_DIVV;
				end
				S_DIVV: if (drsp.done) state_q <= S_SW;
				S_SW:   state_q <= (it_q.dx != 33'sd0) ? S_SWS : S_WT;
				S_SWS:  state_q <= S_SWD;
				S_SWD:  if (drsp.done) state_q <= S_WT;
				S_WT:   state_q <= S_WTD;
				S_WTD:  if (drsp.done) state_q <= cfg.phase ? S_VM : S_P0;
				S_P0:   state_q <= S_OUT;
				S_VM:   state_q <= (b_rd.vhi <= b_rd.vlo) ? S_WM : S_VS;
				S_VS:   state_q <= S_VD;
				S_VD: begin
					if (drsp.done) begin
						if (drsp.quo >= 66'sd0 && drsp.quo < $signed(66'(VELOCITY_BINS)))
							state_q <= S_VR;
						else state_q <= S_WM;
					end
				end
				S_VR: state_q <= S_VW;
				S_VW: state_q <= S_WM;
				S_WM: begin
					if (it_q.dx == 33'sd0 || b_rd.whi <= b_rd.wlo) state_q <= S_OUT;
					else state_q <= S_WS;
				end
				S_WS: state_q <= S_WD;
				S_WD: begin
					if (drsp.done) begin
						if (drsp.quo >= 66'sd0 && drsp.quo < $signed(66'(WORK_BINS)))
							state_q <= S_WR;
						else state_q <= S_OUT;
					end
				end
				S_WR:  state_q <= S_WW;
				S_WW:  state_q <= S_OUT;
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		if (out_load) out_q <= res_q;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					it_q    <= q_item;
					res_q   <= '{direction: q_item.dir, default: '0};
					baddr_q <= tread[TW-1:0];
					vaddr_q <= vread[VA-1:0];
					waddr_q <= wread[WA-1:0];
				end
			end
			S_RDD: begin
				res_q.space_bin <= it_q.sb;
				if (it_q.read_ok) begin
					res_q.accepted <= 1'b1;
					case (it_q.which)
						WH_VEL: begin
							res_q.hit_count  <= v_rd.count;
							res_q.weight_sum <= v_rd.weight;
							res_q.work_sum   <= v_rd.work;
						end
						WH_WORK: begin
							res_q.hit_count  <= w_rd.count;
							res_q.weight_sum <= w_rd.weight;
						end
						default: begin
							res_q.hit_count <= b_rd.used;
							if (it_q.hb == 6'd0) begin
								res_q.work_sum   <= 48'(b_rd.wlo);
								res_q.range_low  <= b_rd.vlo;
								res_q.range_high <= b_rd.vhi;
							end else begin
								res_q.work_sum   <= b_rd.total;
								res_q.range_low  <= b_rd.wlo;
								res_q.range_high <= b_rd.whi;
							end
						end
					endcase
				end
			end
			S_DIVI: if (drsp.done) i_q <= drsp.quo[IW-1:0];
			S_LO: begin
				lo_q    <= 48'(s_c) + 48'(iw_prod);
				t_q     <= tsamp[TW-1:0];
				baddr_q <= tsamp[TW-1:0];
			end
			S_IN: begin
				if (inside_c) begin
					res_q.accepted  <= 1'b1;
					res_q.space_bin <= 6'(i_q);
				end
				// Without a step time the velocity follows the step's sign.
				if (it_q.dx[32]) v_q <= S32_MIN;
				else if (it_q.dx != 33'sd0) v_q <= S32_MAX;
				else v_q <= 32'sd0;
			end
			S_DIVV: if (drsp.done) v_q <= sat32(drsp.quo);
			S_SW:   prod_q <= NUM_W'(sw_prod);
			S_SWD:  if (drsp.done) sw_q <= sat32(drsp.quo);
			S_WTD: begin
				if (drsp.done)
					wt_q <= (drsp.quo[QUO_W-1:48] != '0) ? {48{1'b1}} : drsp.quo[47:0];
			end
			S_VM: begin
				prod_q <= NUM_W'(vm_prod);
				den_q  <= DEN_W'(vspan);
			end
			S_VD: if (drsp.done) vaddr_q <= vsamp[VA-1:0];
			S_WM: begin
				prod_q <= NUM_W'(wm_prod);
				den_q  <= DEN_W'(wspan);
			end
			S_WD: if (drsp.done) waddr_q <= wsamp[WA-1:0];
			default: begin
			end
		endcase
	end

endmodule

[rtl/binned_velocity_work_histogram_top.sv]
// ----------------------------------------------------------------------------
// binned_velocity_work_histogram_top
// Two-table spatially binned velocity and work histogram with range tracking.
// ----------------------------------------------------------------------------
// Requests are handled one at a time by a sequencer behind a two-entry input
// queue, and each result waits in an output register while the next request
// is taken. A table read goes through a memory read and a capture state. A
// sample takes up to six passes through one shared radix-2 divider, each
// producing 65 quotient bits, for the bin index, velocity, scaled work, weight,
// velocity and work histogram index; that divider sets the rate. After reset a
// clearing pass writes every table address to initialize the tables, and no
// request beat is taken until it ends; configuration writes are taken at any
// time and always complete at once.
module binned_velocity_work_histogram_top import bvwh_pkg::*; #(
	parameter int SPACE_BINS    = 64,
	parameter int VELOCITY_BINS = 64,
	parameter int WORK_BINS     = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [31:0] pos_start,
	input  logic signed [31:0] pos_end,
	input  logic signed [31:0] work,
	input  logic               read_direction,
	input  logic        [5:0]  read_space_bin,
	input  logic        [1:0]  read_which,
	input  logic        [5:0]  read_hist_bin,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic               direction,
	output logic        [5:0]  space_bin,
	output logic        [31:0] hit_count,
	output logic        [47:0] weight_sum,
	output logic signed [47:0] work_sum,
	output logic signed [31:0] range_low,
	output logic signed [31:0] range_high,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data
);

	cfg_t   cfg_q;
	logic   q_valid;
	qitem_t q_item;
	logic   q_pop;
	logic   clearing;
	res_t   out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase     <= 1'b0;
			cfg_q.fwd_start <= 32'sd0;
			cfg_q.fwd_width <= 32'sh00010000;
			cfg_q.rev_start <= 32'sd0;
			cfg_q.rev_width <= 32'shFFFF0000;
			cfg_q.step_time <= 32'h00010000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PHASE:     cfg_q.phase     <= cfg_data[0];
				REG_FWD_START: cfg_q.fwd_start <= cfg_data;
				REG_FWD_WIDTH: cfg_q.fwd_width <= cfg_data;
				REG_REV_START: cfg_q.rev_start <= cfg_data;
				REG_REV_WIDTH: cfg_q.rev_width <= cfg_data;
				REG_STEP_TIME: cfg_q.step_time <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bvwh_front #(
		.SPACE_BINS   (SPACE_BINS),
		.VELOCITY_BINS(VELOCITY_BINS),
		.WORK_BINS    (WORK_BINS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.hold          (clearing),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.pos_start     (pos_start),
		.pos_end       (pos_end),
		.work          (work),
		.read_direction(read_direction),
		.read_space_bin(read_space_bin),
		.read_which    (read_which),
		.read_hist_bin (read_hist_bin),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	bvwh_back #(
		.SPACE_BINS   (SPACE_BINS),
		.VELOCITY_BINS(VELOCITY_BINS),
		.WORK_BINS    (WORK_BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.clearing (clearing),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign accepted   = out_res.accepted;
	assign direction  = out_res.direction;
	assign space_bin  = out_res.space_bin;
	assign hit_count  = out_res.hit_count;
	assign weight_sum = out_res.weight_sum;
	assign work_sum   = out_res.work_sum;
	assign range_low  = out_res.range_low;
	assign range_high = out_res.range_high;

endmodule
